FILE: rtl/rlh_pkg.sv
`timescale 1ns / 1ps

package rlh_pkg;

	localparam int NUM_BINS = 256;
	localparam int BIN_BITS = 8;
	localparam int NUM_LANES = 4;
	localparam int OUT_BITS = 32;

	localparam logic [1:0] ACT_PIXEL = 2'd0;
	localparam logic [1:0] ACT_READ  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	localparam int LANE_RED   = 0;
	localparam int LANE_GREEN = 1;
	localparam int LANE_BLUE  = 2;
	localparam int LANE_LUMA  = 3;

	typedef enum logic [1:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_FETCH,
		ST_EMIT
	} rlh_state_t;

	typedef struct packed {
		logic load;
		logic sweep;
		logic update;
		logic emit;
	} rlh_cmd_t;

	typedef struct packed {
		logic [1:0] act;
		logic       last;
		logic       sweep_done;
	} rlh_status_t;

	// x / 3 for 8-bit x: x * 171 >> 9 is exact over 0..255
	function automatic logic [BIN_BITS-1:0] div3(input logic [BIN_BITS-1:0] x);
		logic [15:0] p;
		p = 16'(x) * 16'd171;
		return BIN_BITS'(p[15:9]);
	endfunction

	function automatic logic [BIN_BITS-1:0] luma_bin(input logic [BIN_BITS-1:0] r,
			input logic [BIN_BITS-1:0] g, input logic [BIN_BITS-1:0] b);
		return BIN_BITS'(div3(r) + div3(g) + div3(b));
	endfunction

endpackage

FILE: rtl/rlh_ctrl.sv
`timescale 1ns / 1ps

module rlh_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           action,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rlh_pkg::rlh_cmd_t    cmd,
	input  rlh_pkg::rlh_status_t status
);
	import rlh_pkg::*;

	rlh_state_t state_q, state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (status.sweep_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (action == ACT_PIXEL || action == ACT_READ) begin
						state_d = ST_FETCH;
					end else if (action == ACT_CLEAR) begin
						state_d = ST_SWEEP;
					end
				end
			end
			ST_FETCH: begin
				if (status.act == ACT_PIXEL) begin
					cmd.update = 1'b1;
					state_d = status.last ? ST_EMIT : ST_IDLE;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_SWEEP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/rlh_dp.sv
`timescale 1ns / 1ps

module rlh_dp #(
	parameter int COUNT_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlh_pkg::rlh_cmd_t    cmd,
	output rlh_pkg::rlh_status_t status,
	input  logic [1:0]           action,
	input  logic [7:0]           red_value,
	input  logic [7:0]           green_value,
	input  logic [7:0]           blue_value,
	input  logic [7:0]           bin_index,
	input  logic                 last_pixel,
	output logic [31:0]          red_count,
	output logic [31:0]          green_count,
	output logic [31:0]          blue_count,
	output logic [31:0]          luma_count,
	output logic                 image_done,
	output logic [31:0]          pixels_seen
);
	import rlh_pkg::*;

	logic [1:0]            act_q;
	logic                  last_q;
	logic [BIN_BITS-1:0]   sweep_q;
	logic [COUNT_BITS-1:0] total_q;
	logic [BIN_BITS-1:0]   rd_addr [NUM_LANES];
	logic [BIN_BITS-1:0]   addr_q  [NUM_LANES];
	logic [COUNT_BITS-1:0] sat_val [NUM_LANES+1];
	logic [OUT_BITS-1:0]   res32   [NUM_LANES+1];
	logic [31:0]           red_q, green_q, blue_q, luma_q, seen_q;
	logic                  done_q;

	always_comb begin
		if (action == ACT_PIXEL) begin
			rd_addr[LANE_RED]   = red_value;
			rd_addr[LANE_GREEN] = green_value;
			rd_addr[LANE_BLUE]  = blue_value;
			rd_addr[LANE_LUMA]  = luma_bin(red_value, green_value, blue_value);
		end else begin
			rd_addr[LANE_RED]   = bin_index;
			rd_addr[LANE_GREEN] = bin_index;
			rd_addr[LANE_BLUE]  = bin_index;
			rd_addr[LANE_LUMA]  = bin_index;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			last_q <= last_pixel;
			addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q <= '0;
			total_q <= '0;
		end else if (cmd.sweep) begin
			sweep_q <= sweep_q + 1'b1;
			total_q <= '0;
		end else if (cmd.update) begin
			total_q <= (&total_q) ? total_q : total_q + 1'b1;
		end
	end

	genvar i;
	generate
		for (i = 0; i < NUM_LANES; i++) begin : g_lane
			logic [COUNT_BITS-1:0] mem [NUM_BINS];
			logic [COUNT_BITS-1:0] rd_q;
			logic [COUNT_BITS-1:0] inc;

			assign inc = (&rd_q) ? rd_q : rd_q + 1'b1;

			always_ff @(posedge clk) begin
				if (cmd.sweep) begin
					mem[sweep_q] <= '0;
				end else if (cmd.update) begin
					mem[addr_q[i]] <= inc;
				end
			end

			always_ff @(posedge clk) begin
				if (cmd.load) begin
					rd_q <= mem[rd_addr[i]];
				end
			end

			assign sat_val[i] = rd_q;
		end

		assign sat_val[NUM_LANES] = total_q;

		for (i = 0; i <= NUM_LANES; i++) begin : g_out32
			if (COUNT_BITS > OUT_BITS) begin : g_clip
				assign res32[i] = (|sat_val[i][COUNT_BITS-1:OUT_BITS]) ?
					'1 : sat_val[i][OUT_BITS-1:0];
			end else begin : g_ext
				assign res32[i] = OUT_BITS'(sat_val[i]);
			end
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			done_q <= (act_q == ACT_PIXEL);
			seen_q <= res32[NUM_LANES];
			if (act_q == ACT_PIXEL) begin
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
				luma_q  <= '0;
			end else begin
				red_q   <= res32[LANE_RED];
				green_q <= res32[LANE_GREEN];
				blue_q  <= res32[LANE_BLUE];
				luma_q  <= res32[LANE_LUMA];
			end
		end
	end

	assign status.act        = act_q;
	assign status.last       = last_q;
	assign status.sweep_done = &sweep_q;

	assign red_count   = red_q;
	assign green_count = green_q;
	assign blue_count  = blue_q;
	assign luma_count  = luma_q;
	assign image_done  = done_q;
	assign pixels_seen = seen_q;

endmodule

FILE: rtl/rgb_luma_histogram.sv
`timescale 1ns / 1ps

// RGB + luma histogram unit. Each pixel request bumps one bin in each of four
// 256-bin histograms (luma bin = r/3 + g/3 + b/3) and the pixel total; counts
// saturate at 2^COUNT_BITS-1 and are reported clipped to 32 bits. A pixel
// marked last answers with the pixel total, a read request with one bin's four
// counts, a clear request gives no answer. A pixel not marked last holds the
// input through the registered read of the bin memories and the write-back; a
// last pixel or a read holds it through read, write-back or fetch, and answer,
// plus any wait for the output register to free up. An action 3 request is only
// accepted; the unit stays idle. After reset the four bin memories are zeroed
// one bin per cycle, with in_ready low; a clear is accepted and zeroes them alike.
module rgb_luma_histogram #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [7:0]  red_value,
	input  logic [7:0]  green_value,
	input  logic [7:0]  blue_value,
	input  logic [7:0]  bin_index,
	input  logic        last_pixel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] red_count,
	output logic [31:0] green_count,
	output logic [31:0] blue_count,
	output logic [31:0] luma_count,
	output logic        image_done,
	output logic [31:0] pixels_seen
);
	import rlh_pkg::*;

	rlh_cmd_t    cmd;
	rlh_status_t status;

	rlh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	rlh_dp #(
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.action      (action),
		.red_value   (red_value),
		.green_value (green_value),
		.blue_value  (blue_value),
		.bin_index   (bin_index),
		.last_pixel  (last_pixel),
		.red_count   (red_count),
		.green_count (green_count),
		.blue_count  (blue_count),
		.luma_count  (luma_count),
		.image_done  (image_done),
		.pixels_seen (pixels_seen)
	);

endmodule

FILE: rtl/rlh_checker.sv
`timescale 1ns / 1ps

module rlh_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic [1:0]  action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] red_count,
	input logic [31:0] green_count,
	input logic [31:0] blue_count,
	input logic [31:0] luma_count,
	input logic        image_done,
	input logic [31:0] pixels_seen
);
	import rlh_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixels_seen) &&
		$stable(image_done) && $stable(red_count) && $stable(luma_count))
		else $error("result changed while stalled");

	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> red_count == 0 && green_count == 0 &&
		blue_count == 0 && luma_count == 0)
		else $error("done result carries bin counts");

	a_done_seen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && image_done |-> pixels_seen != 0)
		else $error("done result with empty pixel total");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready &&
		(action == ACT_PIXEL || action == ACT_READ || action == ACT_CLEAR)
		|=> !in_ready)
		else $error("request taken while previous one in flight");

endmodule

bind rgb_luma_histogram rlh_checker u_rlh_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.action      (action),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.red_count   (red_count),
	.green_count (green_count),
	.blue_count  (blue_count),
	.luma_count  (luma_count),
	.image_done  (image_done),
	.pixels_seen (pixels_seen)
);
